/* src/ipv4lpm_pkg.sv */
// Shared types, codes and helpers for the IPv4 longest-prefix-match table.
// No dependencies; every other file in src uses this package.
package ipv4lpm_pkg;

    localparam int unsigned TABLE_ENTRIES_DEF = 64;
    localparam int unsigned ADDR_W            = 32;
    localparam int unsigned LEN_W             = 6;
    localparam logic [LEN_W-1:0] MAX_LEN      = 6'd32;

    typedef enum logic [1:0] {
        KIND_LOOKUP = 2'd0,
        KIND_ADD    = 2'd1,
        KIND_DELETE = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_BAD_LEN = 2'd1,
        ST_FULL    = 2'd2,
        ST_ABSENT  = 2'd3
    } status_t;

    // One request walking the cell chain, with what it has gathered so far.
    typedef struct packed {
        logic              active;
        logic              commit;
        logic [1:0]        kind;
        logic [ADDR_W-1:0] base;
        logic [LEN_W-1:0]  len;
        logic              found;
        logic [LEN_W-1:0]  mlen;
        logic              hit;
        logic              free_seen;
        logic              claimed;
    } token_t;

    typedef struct packed {
        logic             found;
        logic [LEN_W-1:0] mlen;
        status_t          status;
    } result_t;

    // Keep the first len bits of an address; len above 32 keeps all.
    function automatic logic [ADDR_W-1:0] len_mask(input logic [LEN_W-1:0] len);
        logic [ADDR_W-1:0] mask;
        if (len >= MAX_LEN) begin
            mask = '1;
        end
        else begin
            mask = ~({ADDR_W{1'b1}} >> len);
        end
        return mask;
    endfunction

endpackage

/* src/ipv4lpm_if.sv */
// Request and response channel interfaces of the prefix table.
// Depends on ipv4lpm_pkg for field widths.
interface ipv4lpm_req_if;
    logic                            valid;
    logic                            ready;
    logic [1:0]                      kind;
    logic [ipv4lpm_pkg::ADDR_W-1:0]  address;
    logic [ipv4lpm_pkg::LEN_W-1:0]   prefix_len;

    modport source (output valid, output kind, output address, output prefix_len,
                    input ready);
    modport sink   (input valid, input kind, input address, input prefix_len,
                    output ready);
endinterface

interface ipv4lpm_rsp_if;
    logic                            valid;
    logic                            ready;
    logic                            match_found;
    logic [ipv4lpm_pkg::LEN_W-1:0]   match_len;
    logic [1:0]                      status;

    modport source (output valid, output match_found, output match_len, output status,
                    input ready);
    modport sink   (input valid, input match_found, input match_len, input status,
                    output ready);
endinterface

/* src/ipv4_longest_prefix_match.sv */
// Top level of the IPv4 longest-prefix-match table: controller and cell chain.
// Depends on ipv4lpm_pkg, ipv4lpm_if, ipv4lpm_cell and ipv4lpm_ctrl.
//
//   channel | modport | payload                          | moves
//   req     | sink    | kind, address, prefix_len        | one request per item
//   rsp     | source  | match_found, match_len, status   | one response per request
//
// A request walks the chain one cell per cycle, so N = TABLE_ENTRIES sets the latency.
// Lookups, rejected updates and duplicate adds are answered after a single walk.
// Adds and deletes that change the table take a second walk before the response.
// One request is in flight at a time; the next is taken while a response waits.
// Reset empties the table at once; a stalled response holds and the next result waits in one pending register.
module ipv4_longest_prefix_match #(
    parameter int unsigned TABLE_ENTRIES = ipv4lpm_pkg::TABLE_ENTRIES_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    ipv4lpm_req_if.sink   req,
    ipv4lpm_rsp_if.source rsp
);

    ipv4lpm_pkg::token_t link [TABLE_ENTRIES+1];

    ipv4lpm_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp),
        .head  (link[0]),
        .tail  (link[TABLE_ENTRIES])
    );

    for (genvar i = 0; i < TABLE_ENTRIES; i++)
    begin : g_cell
        ipv4lpm_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .tok_in  (link[i]),
            .tok_out (link[i+1])
        );
    end

endmodule

/* src/ipv4lpm_cell.sv */
// One table entry of the prefix chain: holds a prefix and passes the request on.
// Depends on ipv4lpm_pkg for token_t, kind codes and len_mask.
module ipv4lpm_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  ipv4lpm_pkg::token_t tok_in,
    output ipv4lpm_pkg::token_t tok_out
);

    logic                           valid_reg;
    logic                           valid_next;
    logic [ipv4lpm_pkg::ADDR_W-1:0] prefix_reg;
    logic [ipv4lpm_pkg::LEN_W-1:0]  length_reg;
    logic                           write_en;
    logic                           exact;
    logic                           covers;
    logic                           active_reg;
    ipv4lpm_pkg::token_t            tok_reg;
    ipv4lpm_pkg::token_t            tok_next;

    assign exact  = valid_reg && (length_reg == tok_in.len) && (prefix_reg == tok_in.base);
    assign covers = valid_reg
                    && ((tok_in.base & ipv4lpm_pkg::len_mask(length_reg)) == prefix_reg);

    always_comb
    begin
        tok_next   = tok_in;
        valid_next = valid_reg;
        write_en   = 1'b0;
        if (tok_in.active)
        begin
            if (!tok_in.commit)
            begin
                if (tok_in.kind == ipv4lpm_pkg::KIND_LOOKUP)
                begin
                    if (covers && (!tok_in.found || (length_reg > tok_in.mlen)))
                    begin
                        tok_next.found = 1'b1;
                        tok_next.mlen  = length_reg;
                    end
                end
                else
                begin
                    tok_next.hit       = tok_in.hit | exact;
                    tok_next.free_seen = tok_in.free_seen | !valid_reg;
                end
            end
            else
            begin
                // claim the first free entry, or drop the matching one
                if ((tok_in.kind == ipv4lpm_pkg::KIND_ADD) && !valid_reg && !tok_in.claimed)
                begin
                    write_en         = 1'b1;
                    valid_next       = 1'b1;
                    tok_next.claimed = 1'b1;
                end
                if ((tok_in.kind == ipv4lpm_pkg::KIND_DELETE) && exact)
                begin
                    valid_next = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= 1'b0;
            active_reg <= 1'b0;
        end
        else
        begin
            valid_reg  <= valid_next;
            active_reg <= tok_in.active;
        end
    end

    always_ff @(posedge clk)
    begin
        tok_reg <= tok_next;
        if (write_en)
        begin
            prefix_reg <= tok_in.base;
            length_reg <= tok_in.len;
        end
    end

    always_comb
    begin
        tok_out        = tok_reg;
        tok_out.active = active_reg;
    end

endmodule

/* src/ipv4lpm_ctrl.sv */
// Request intake, second-pass dispatch and response register of the prefix table.
// Depends on ipv4lpm_pkg and the channel interfaces in ipv4lpm_if.
module ipv4lpm_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    ipv4lpm_req_if.sink         req,
    ipv4lpm_rsp_if.source       rsp,
    output ipv4lpm_pkg::token_t head,
    input  ipv4lpm_pkg::token_t tail
);

    logic                 busy_reg;
    logic                 busy_next;
    logic                 head_active_reg;
    logic                 head_active_next;
    ipv4lpm_pkg::token_t  head_reg;
    ipv4lpm_pkg::token_t  head_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    ipv4lpm_pkg::result_t out_reg;
    ipv4lpm_pkg::result_t out_next;
    logic                 pend_valid_reg;
    logic                 pend_valid_next;
    ipv4lpm_pkg::result_t pend_reg;
    ipv4lpm_pkg::result_t pend_next;
    ipv4lpm_pkg::result_t tail_res;
    logic                 needs_commit;
    logic                 final_valid;
    logic                 accept;
    logic                 out_free;
    logic                 bad_len;

    assign req.ready = !busy_reg;
    assign accept    = req.valid && !busy_reg;
    assign bad_len   = tail.len > ipv4lpm_pkg::MAX_LEN;

    // decide the outcome of a request leaving the chain
    always_comb
    begin
        tail_res.found  = 1'b0;
        tail_res.mlen   = '0;
        tail_res.status = ipv4lpm_pkg::ST_OK;
        needs_commit    = 1'b0;
        if (!tail.commit)
        begin
            case (tail.kind)
                ipv4lpm_pkg::KIND_LOOKUP:
                begin
                    tail_res.found = tail.found;
                    tail_res.mlen  = tail.mlen;
                end
                ipv4lpm_pkg::KIND_ADD:
                begin
                    if (bad_len)
                        tail_res.status = ipv4lpm_pkg::ST_BAD_LEN;
                    else if (tail.hit)
                        tail_res.status = ipv4lpm_pkg::ST_OK;
                    else if (!tail.free_seen)
                        tail_res.status = ipv4lpm_pkg::ST_FULL;
                    else
                        needs_commit = 1'b1;
                end
                ipv4lpm_pkg::KIND_DELETE:
                begin
                    if (bad_len)
                        tail_res.status = ipv4lpm_pkg::ST_BAD_LEN;
                    else if (!tail.hit)
                        tail_res.status = ipv4lpm_pkg::ST_ABSENT;
                    else
                        needs_commit = 1'b1;
                end
                default:
                begin
                    tail_res.status = ipv4lpm_pkg::ST_OK;
                end
            endcase
        end
    end

    assign final_valid = tail.active && !needs_commit;

    always_comb
    begin
        head_next        = head_reg;
        head_active_next = 1'b0;
        if (accept)
        begin
            head_active_next   = 1'b1;
            head_next.commit   = 1'b0;
            head_next.kind     = req.kind;
            head_next.len      = req.prefix_len;
            head_next.base     = (req.kind == ipv4lpm_pkg::KIND_LOOKUP) ? req.address
                                 : (req.address & ipv4lpm_pkg::len_mask(req.prefix_len));
            head_next.found     = 1'b0;
            head_next.mlen      = '0;
            head_next.hit       = 1'b0;
            head_next.free_seen = 1'b0;
            head_next.claimed   = 1'b0;
        end
        else if (tail.active && needs_commit)
        begin
            head_active_next  = 1'b1;
            head_next         = tail;
            head_next.commit  = 1'b1;
            head_next.claimed = 1'b0;
        end
    end

    assign out_free = !out_valid_reg || rsp.ready;

    always_comb
    begin
        busy_next       = busy_reg;
        out_valid_next  = out_valid_reg;
        out_next        = out_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        if (accept)
            busy_next = 1'b1;
        if (out_free)
        begin
            if (pend_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_next        = pend_reg;
                pend_valid_next = 1'b0;
                busy_next       = 1'b0;
            end
            else if (final_valid)
            begin
                out_valid_next = 1'b1;
                out_next       = tail_res;
                busy_next      = 1'b0;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
        else if (final_valid)
        begin
            // hold the result until the response register drains
            pend_valid_next = 1'b1;
            pend_next       = tail_res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg        <= 1'b0;
            head_active_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
            pend_valid_reg  <= 1'b0;
        end
        else
        begin
            busy_reg        <= busy_next;
            head_active_reg <= head_active_next;
            out_valid_reg   <= out_valid_next;
            pend_valid_reg  <= pend_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        head_reg <= head_next;
        out_reg  <= out_next;
        pend_reg <= pend_next;
    end

    always_comb
    begin
        head        = head_reg;
        head.active = head_active_reg;
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.match_found = out_reg.found;
    assign rsp.match_len   = out_reg.mlen;
    assign rsp.status      = out_reg.status;

endmodule

/* verif/testbench.sv */
// Self-checking testbench for the IPv4 longest-prefix-match table.
// Depends on ipv4lpm_pkg, ipv4lpm_if and ipv4_longest_prefix_match from src;
// a directed table runs first, then random fill and drain traffic.
`timescale 1ns / 100ps

module testbench;
    import ipv4lpm_pkg::*;

    localparam int unsigned TABLE_ENTRIES  = 64;
    localparam int          RANDOM_ITEMS   = 1526;
    localparam int          QUIET_ITEMS    = 150;
    localparam int          WATCHDOG_LIMIT = 2000;

    localparam logic [1:0] KIND_UNUSED = 2'd3;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] address;
        logic [5:0]  prefix_len;
        logic        typed;
        result_t     want;
    } stim_row_t;

    localparam result_t NO_MATCH    = '{1'b0, 6'd0, ST_OK};
    localparam result_t BAD_LEN_RSP = '{1'b0, 6'd0, ST_BAD_LEN};
    localparam result_t ABSENT_RSP  = '{1'b0, 6'd0, ST_ABSENT};

    localparam int DIRECTED_ROWS = 24;
    localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
        '{KIND_LOOKUP, 32'h0000_0000, 6'd0,  1'b1, NO_MATCH},
        '{KIND_LOOKUP, 32'hFFFF_FFFF, 6'd63, 1'b1, NO_MATCH},
        '{KIND_DELETE, 32'h0000_0000, 6'd0,  1'b1, ABSENT_RSP},
        '{KIND_ADD,    32'h0000_0000, 6'd33, 1'b1, BAD_LEN_RSP},
        '{KIND_ADD,    32'hFFFF_FFFF, 6'd63, 1'b1, BAD_LEN_RSP},
        '{KIND_DELETE, 32'hFFFF_FFFF, 6'd63, 1'b1, BAD_LEN_RSP},
        '{KIND_UNUSED, 32'hFFFF_FFFF, 6'd63, 1'b1, NO_MATCH},
        '{KIND_ADD,    32'h1234_5678, 6'd0,  1'b1, NO_MATCH},
        '{KIND_LOOKUP, 32'hFFFF_FFFF, 6'd0,  1'b0, NO_MATCH},
        '{KIND_ADD,    32'hFFFF_FFFF, 6'd32, 1'b1, NO_MATCH},
        '{KIND_LOOKUP, 32'hFFFF_FFFF, 6'd0,  1'b0, NO_MATCH},
        '{KIND_LOOKUP, 32'hFFFF_FFFE, 6'd0,  1'b0, NO_MATCH},
        '{KIND_ADD,    32'hC0A8_FFFF, 6'd16, 1'b1, NO_MATCH},
        '{KIND_ADD,    32'hC0A8_0000, 6'd16, 1'b1, NO_MATCH},
        '{KIND_LOOKUP, 32'hC0A8_1234, 6'd0,  1'b0, NO_MATCH},
        '{KIND_ADD,    32'h8000_0000, 6'd1,  1'b1, NO_MATCH},
        '{KIND_LOOKUP, 32'hC0A8_1234, 6'd0,  1'b0, NO_MATCH},
        '{KIND_DELETE, 32'hC0A8_ABCD, 6'd16, 1'b1, NO_MATCH},
        '{KIND_DELETE, 32'hC0A8_0000, 6'd16, 1'b1, ABSENT_RSP},
        '{KIND_LOOKUP, 32'hC0A8_1234, 6'd0,  1'b0, NO_MATCH},
        '{KIND_DELETE, 32'h0000_0000, 6'd0,  1'b1, NO_MATCH},
        '{KIND_LOOKUP, 32'h1234_5678, 6'd0,  1'b0, NO_MATCH},
        '{KIND_DELETE, 32'hFFFF_FFFF, 6'd32, 1'b1, NO_MATCH},
        '{KIND_DELETE, 32'hFFFF_FFFF, 6'd1,  1'b1, NO_MATCH}
    };

    logic clk;
    logic rst_n;

    ipv4lpm_req_if req_ch ();
    ipv4lpm_rsp_if rsp_ch ();

    ipv4_longest_prefix_match #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    logic        tbl_valid [TABLE_ENTRIES];
    logic [31:0] tbl_base  [TABLE_ENTRIES];
    logic [5:0]  tbl_len   [TABLE_ENTRIES];
    int          tbl_count;

    result_t owed_responses [$];
    int      mismatch_count;
    int      idle_cycles;
    bit      tail_quiet;
    bit      filling;

    function automatic logic [31:0] lead_mask(input logic [5:0] len);
        logic [63:0] wide;
        wide = 64'hFFFF_FFFF << (32 - int'(len));
        return wide[31:0];
    endfunction

    function automatic result_t lookup_or_update(input logic [1:0] kind,
                                                 input logic [31:0] addr,
                                                 input logic [5:0] len);
        result_t     res;
        logic [31:0] base;
        int          hit;
        int          slot;
        res  = NO_MATCH;
        hit  = -1;
        slot = -1;
        if (kind == KIND_LOOKUP)
        begin
            for (int i = 0; i < TABLE_ENTRIES; i++)
            begin
                if (tbl_valid[i] && (addr & lead_mask(tbl_len[i])) == tbl_base[i])
                begin
                    if (!res.found || tbl_len[i] > res.mlen)
                    begin
                        res.mlen = tbl_len[i];
                    end
                    res.found = 1'b1;
                end
            end
        end
        else if (kind == KIND_ADD || kind == KIND_DELETE)
        begin
            if (len > MAX_LEN)
            begin
                res.status = ST_BAD_LEN;
            end
            else
            begin
                base = addr & lead_mask(len);
                for (int i = 0; i < TABLE_ENTRIES; i++)
                begin
                    if (hit < 0 && tbl_valid[i] && tbl_len[i] == len && tbl_base[i] == base)
                    begin
                        hit = i;
                    end
                    if (slot < 0 && !tbl_valid[i])
                    begin
                        slot = i;
                    end
                end
                if (kind == KIND_ADD && hit < 0)
                begin
                    if (slot < 0)
                    begin
                        res.status = ST_FULL;
                    end
                    else
                    begin
                        tbl_valid[slot] = 1'b1;
                        tbl_base[slot]  = base;
                        tbl_len[slot]   = len;
                        tbl_count++;
                    end
                end
                else if (kind == KIND_DELETE)
                begin
                    if (hit < 0)
                    begin
                        res.status = ST_ABSENT;
                    end
                    else
                    begin
                        tbl_valid[hit] = 1'b0;
                        tbl_count--;
                    end
                end
            end
        end
        return res;
    endfunction

    function automatic int pick_stored();
        int start;
        int idx;
        start = $urandom_range(0, TABLE_ENTRIES - 1);
        for (int i = 0; i < TABLE_ENTRIES; i++)
        begin
            idx = (start + i) % TABLE_ENTRIES;
            if (tbl_valid[idx])
            begin
                return idx;
            end
        end
        return start;
    endfunction

    task automatic pick_random(output logic [1:0] kind, output logic [31:0] addr,
                               output logic [5:0] len);
        int unsigned roll;
        int unsigned add_share;
        int          idx;
        roll      = $urandom_range(0, 99);
        add_share = filling ? 45 : 12;
        addr      = $urandom();
        len       = 6'($urandom_range(0, 32));
        kind      = KIND_LOOKUP;
        if (roll < 4)
        begin
            kind = KIND_UNUSED;
            len  = 6'($urandom_range(0, 63));
        end
        else if (roll < 9)
        begin
            kind = $urandom_range(0, 1) ? KIND_ADD : KIND_DELETE;
            len  = 6'($urandom_range(33, 63));
        end
        else if (roll < 45)
        begin
            len = 6'($urandom_range(0, 63));
            if (tbl_count > 0 && $urandom_range(0, 2) != 0)
            begin
                idx  = pick_stored();
                addr = tbl_base[idx] | ($urandom() & ~lead_mask(tbl_len[idx]));
            end
        end
        else
        begin
            kind = (roll < 45 + add_share) ? KIND_ADD : KIND_DELETE;
            if (tbl_count > 0 && (kind == KIND_DELETE ? $urandom_range(0, 3) != 0
                                                      : $urandom_range(0, 9) == 0))
            begin
                idx  = pick_stored();
                len  = tbl_len[idx];
                addr = tbl_base[idx] | ($urandom() & ~lead_mask(len));
            end
        end
    endtask

    task automatic report_mismatch(input string msg);
        $display("%0t ns mismatch: %s", $realtime, msg);
        mismatch_count++;
    endtask

    task automatic send_request(input logic [1:0] kind, input logic [31:0] addr,
                                input logic [5:0] len, input logic typed,
                                input result_t want);
        result_t predicted;
        if (!tail_quiet && $urandom_range(0, 4) == 0)
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.kind       <= kind;
        req_ch.address    <= addr;
        req_ch.prefix_len <= len;
        @(posedge clk);
        while (!req_ch.ready)
        begin
            @(posedge clk);
        end
        predicted = lookup_or_update(kind, addr, len);
        owed_responses.push_back(typed ? want : predicted);
    endtask

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        rst_n <= 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
    end

    initial
    begin
        rsp_ch.ready <= 1'b0;
        wait (rst_n);
        forever
        begin
            if (!tail_quiet && $urandom_range(0, 2) == 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge clk);
            end
            rsp_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
    end

    always @(posedge clk)
    begin : check_response
        result_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (owed_responses.size() == 0)
            begin
                report_mismatch("response with no request outstanding");
            end
            else
            begin
                want = owed_responses.pop_front();
                if (rsp_ch.match_found !== want.found)
                begin
                    report_mismatch($sformatf("match_found %b, want %b",
                                              rsp_ch.match_found, want.found));
                end
                if (rsp_ch.match_len !== want.mlen)
                begin
                    report_mismatch($sformatf("match_len %0d, want %0d",
                                              rsp_ch.match_len, want.mlen));
                end
                if (rsp_ch.status !== want.status)
                begin
                    report_mismatch($sformatf("status %0d, want %0d",
                                              rsp_ch.status, want.status));
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    initial
    begin : drive_requests
        logic [1:0]  kind;
        logic [31:0] addr;
        logic [5:0]  len;
        mismatch_count    = 0;
        tail_quiet        = 1'b0;
        filling           = 1'b1;
        tbl_count         = 0;
        for (int i = 0; i < TABLE_ENTRIES; i++)
        begin
            tbl_valid[i] = 1'b0;
        end
        req_ch.valid      <= 1'b0;
        req_ch.kind       <= KIND_LOOKUP;
        req_ch.address    <= '0;
        req_ch.prefix_len <= '0;
        wait (rst_n);
        @(posedge clk);

        for (int r = 0; r < DIRECTED_ROWS; r++)
        begin
            send_request(DIRECTED[r].kind, DIRECTED[r].address, DIRECTED[r].prefix_len,
                         DIRECTED[r].typed, DIRECTED[r].want);
        end

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            tail_quiet = (n >= RANDOM_ITEMS - QUIET_ITEMS);
            pick_random(kind, addr, len);
            send_request(kind, addr, len, 1'b0, NO_MATCH);
            if (filling && tbl_count == TABLE_ENTRIES && $urandom_range(0, 11) == 0)
            begin
                filling = 1'b0;
            end
            else if (!filling && $urandom_range(0, 6) >= tbl_count)
            begin
                filling = 1'b1;
            end
        end
        req_ch.valid <= 1'b0;

        while (owed_responses.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (2 * TABLE_ENTRIES + 8) @(posedge clk);
        if (owed_responses.size() != 0)
        begin
            report_mismatch($sformatf("%0d responses never arrived", owed_responses.size()));
        end

        if (mismatch_count == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
